@@ hdl/set_assoc_cache_fifo_write_through_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the set-associative cache.
// Each macro expects clk_i and rst_ni to be visible where it is used.
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_CACHE_FIFO_WRITE_THROUGH_MACROS_SVH
`define SET_ASSOC_CACHE_FIFO_WRITE_THROUGH_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SACF_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SACF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/sacfwt_pkg.sv @@
// ----------------------------------------------------------------------------
// sacfwt_pkg
// Geometry, widths and reset values of the set-associative cache.
// ----------------------------------------------------------------------------
package sacfwt_pkg;

  localparam int WAYS            = 4;
  localparam int SETS            = 4;
  localparam int WORDS_PER_BLOCK = 4;
  localparam int MEM_WORDS       = 1024;

  localparam int DATA_W  = 32;
  localparam int ADDR_W  = $clog2(MEM_WORDS);
  localparam int WAY_W   = $clog2(WAYS);
  localparam int SET_W   = $clog2(SETS);
  localparam int OFF_W   = $clog2(WORDS_PER_BLOCK);
  localparam int BLK_W   = ADDR_W - OFF_W;
  localparam int CD_WORDS = SETS * WAYS * WORDS_PER_BLOCK;
  localparam int CD_AW   = $clog2(CD_WORDS);
  localparam int LIMIT_W = ADDR_W + 1;
  localparam int CNT_W   = 32;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(MEM_WORDS);

  typedef logic [DATA_W-1:0] word_t;
  typedef logic [BLK_W-1:0]  blk_t;
  typedef logic [WAY_W-1:0]  way_t;

endpackage

@@ hdl/set_assoc_cache_fifo_write_through.sv @@
// ----------------------------------------------------------------------------
// set_assoc_cache_fifo_write_through
// Four-way set-associative cache with FIFO victim choice, write-through and
// write-allocate, in front of a word-addressed backing memory.
// ----------------------------------------------------------------------------
//  channel | handshake                | payload
//  --------+--------------------------+------------------------------------------
//  in      | in_valid_i / in_ready_o  | mode_i, address_i, write_value_i
//  out     | out_valid_o / out_ready_i| hit_o, read_value_o, way_used_o,
//          |                          | status_o, total_hits_o
//  cfg     | cfg_we_i                 | cfg_wdata_i (address limit)
//
// A read hit goes through lookup, a line-data read and the response; a write hit
// or a rejected address goes from lookup to the response. A miss refills the line
// one word a cycle over the single port of the backing memory. After reset a pass
// over all MEM_WORDS addresses zeroes both memories; no beat is accepted
// meanwhile. A finished result waits in the output register while the block
// takes the next beat; it only stalls at the end of that item if still unread.
// ----------------------------------------------------------------------------
`include "set_assoc_cache_fifo_write_through_macros.svh"

module set_assoc_cache_fifo_write_through
  import sacfwt_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [LIMIT_W-1:0]        cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      mode_i,
  input  logic [ADDR_W-1:0]         address_i,
  input  logic signed [DATA_W-1:0]  write_value_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      hit_o,
  output logic signed [DATA_W-1:0]  read_value_o,
  output logic [WAY_W-1:0]          way_used_o,
  output logic                      status_o,
  output logic [CNT_W-1:0]          total_hits_o
);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_LOOK   = 3'd2;
  localparam logic [2:0] ST_HITRD  = 3'd3;
  localparam logic [2:0] ST_FILL   = 3'd4;
  localparam logic [2:0] ST_FDRAIN = 3'd5;
  localparam logic [2:0] ST_RESP   = 3'd6;

  logic [2:0]          state_q, state_d;
  logic [ADDR_W-1:0]   clr_cnt_q, clr_cnt_d;
  logic [LIMIT_W-1:0]  limit_q;
  logic [OFF_W-1:0]    k_q, k_d;
  logic                fill_rv_q, fill_rv_d;
  logic [OFF_W-1:0]    fill_rk_q;
  logic [CNT_W-1:0]    hits_q, hits_d;
  logic                out_valid_q, out_valid_d;
  logic                out_load;

  // Item registers.
  logic                mode_q;
  logic [ADDR_W-1:0]   addr_q;
  word_t               wval_q;
  logic                oor_q;

  // Result being assembled.
  logic                res_hit_q, res_hit_d;
  word_t               res_data_q, res_data_d;
  way_t                res_way_q, res_way_d;
  logic                res_status_q, res_status_d;

  // Output register.
  logic                out_hit_q;
  word_t               out_data_q;
  way_t                out_way_q;
  logic                out_status_q;
  logic [CNT_W-1:0]    out_hits_q;

  // Tags and FIFO pointers.
  blk_t                tag_q [SETS][WAYS];
  way_t                fp_q  [SETS];

  // Memories.
  word_t               bm_mem [MEM_WORDS];
  word_t               cd_mem [CD_WORDS];
  logic                bm_we;
  logic [ADDR_W-1:0]   bm_addr;
  word_t               bm_wdata;
  word_t               bm_rdata_q;
  logic                cd_we;
  logic [CD_AW-1:0]    cd_waddr;
  word_t               cd_wdata;
  logic [CD_AW-1:0]    cd_raddr;
  word_t               cd_rdata_q;

  blk_t                blk;
  logic [SET_W-1:0]    set_idx;
  logic [OFF_W-1:0]    off;
  logic                lk_hit;
  way_t                lk_way;
  word_t               fill_word;
  logic                in_fire;
  logic                miss_upd;

  assign blk      = addr_q[ADDR_W-1:OFF_W];
  assign set_idx  = addr_q[OFF_W +: SET_W];
  assign off      = addr_q[OFF_W-1:0];
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire  = in_valid_i && in_ready_o;
  assign miss_upd = (state_q == ST_LOOK) && !oor_q && !lk_hit;

  // Lowest matching way wins, although a block never sits twice in a set.
  always_comb begin
    lk_hit = 1'b0;
    lk_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (tag_q[set_idx][w] == blk) begin
        lk_hit = 1'b1;
        lk_way = WAY_W'(w);
      end
    end
  end

  // A write miss merges the new word into the line as it is refilled.
  assign fill_word = (mode_q && (fill_rk_q == off)) ? wval_q : bm_rdata_q;
  assign cd_raddr  = {set_idx, lk_way, off};

  always_comb begin
    state_d      = state_q;
    clr_cnt_d    = clr_cnt_q;
    k_d          = k_q;
    fill_rv_d    = 1'b0;
    hits_d       = hits_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_load     = 1'b0;
    res_hit_d    = res_hit_q;
    res_data_d   = res_data_q;
    res_way_d    = res_way_q;
    res_status_d = res_status_q;
    bm_we        = 1'b0;
    bm_addr      = {blk, k_q};
    bm_wdata     = wval_q;
    cd_we        = 1'b0;
    cd_waddr     = {set_idx, res_way_q, fill_rk_q};
    cd_wdata     = fill_word;

    if (fill_rv_q) begin
      cd_we = 1'b1;
      if (fill_rk_q == off) begin
        res_data_d = fill_word;
      end
    end

    unique case (state_q)
      ST_CLEAR: begin
        bm_we     = 1'b1;
        bm_addr   = clr_cnt_q;
        bm_wdata  = '0;
        cd_we     = 1'b1;
        cd_waddr  = clr_cnt_q[CD_AW-1:0];
        cd_wdata  = '0;
        clr_cnt_d = clr_cnt_q + ADDR_W'(1);
        if (clr_cnt_q == ADDR_W'(MEM_WORDS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (oor_q) begin
          res_hit_d    = 1'b0;
          res_data_d   = '0;
          res_way_d    = '0;
          res_status_d = 1'b1;
          state_d      = ST_RESP;
        end else if (lk_hit) begin
          hits_d       = hits_q + CNT_W'(1);
          res_hit_d    = 1'b1;
          res_way_d    = lk_way;
          res_status_d = 1'b0;
          if (mode_q) begin
            bm_we      = 1'b1;
            bm_addr    = addr_q;
            cd_we      = 1'b1;
            cd_waddr   = {set_idx, lk_way, off};
            cd_wdata   = wval_q;
            res_data_d = wval_q;
            state_d    = ST_RESP;
          end else begin
            state_d    = ST_HITRD;
          end
        end else begin
          res_hit_d    = 1'b0;
          res_way_d    = fp_q[set_idx];
          res_status_d = 1'b0;
          k_d          = '0;
          state_d      = ST_FILL;
        end
      end
      ST_HITRD: begin
        res_data_d = cd_rdata_q;
        state_d    = ST_RESP;
      end
      ST_FILL: begin
        fill_rv_d = 1'b1;
        k_d       = k_q + OFF_W'(1);
        if (k_q == OFF_W'(WORDS_PER_BLOCK - 1)) begin
          state_d = ST_FDRAIN;
        end
      end
      ST_FDRAIN: begin
        // The last refill beat lands in the line; the port is free for the write.
        if (mode_q) begin
          bm_we   = 1'b1;
          bm_addr = addr_q;
        end
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      limit_q     <= LIMIT_RESET;
      k_q         <= '0;
      fill_rv_q   <= 1'b0;
      hits_q      <= '0;
      out_valid_q <= 1'b0;
      for (int s = 0; s < SETS; s++) begin
        fp_q[s] <= '0;
        for (int w = 0; w < WAYS; w++) begin
          tag_q[s][w] <= BLK_W'(w * SETS + s);
        end
      end
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      k_q         <= k_d;
      fill_rv_q   <= fill_rv_d;
      hits_q      <= hits_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (miss_upd) begin
        tag_q[set_idx][fp_q[set_idx]] <= blk;
        if (fp_q[set_idx] == WAY_W'(WAYS - 1)) begin
          fp_q[set_idx] <= '0;
        end else begin
          fp_q[set_idx] <= fp_q[set_idx] + WAY_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mode_q <= mode_i;
      addr_q <= address_i;
      wval_q <= $unsigned(write_value_i);
      oor_q  <= ({1'b0, address_i} >= limit_q);
    end
    fill_rk_q    <= k_q;
    res_hit_q    <= res_hit_d;
    res_data_q   <= res_data_d;
    res_way_q    <= res_way_d;
    res_status_q <= res_status_d;
    if (out_load) begin
      out_hit_q    <= res_hit_q;
      out_data_q   <= res_data_q;
      out_way_q    <= res_way_q;
      out_status_q <= res_status_q;
      out_hits_q   <= hits_q;
    end
  end

  // Backing memory: single port, read data registered.
  always_ff @(posedge clk_i) begin
    if (bm_we) begin
      bm_mem[bm_addr] <= bm_wdata;
    end else begin
      bm_rdata_q <= bm_mem[bm_addr];
    end
  end

  // Line data: one write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (cd_we) begin
      cd_mem[cd_waddr] <= cd_wdata;
    end
    cd_rdata_q <= cd_mem[cd_raddr];
  end

  assign out_valid_o  = out_valid_q;
  assign hit_o        = out_hit_q;
  assign read_value_o = $signed(out_data_q);
  assign way_used_o   = out_way_q;
  assign status_o     = out_status_q;
  assign total_hits_o = out_hits_q;

  `SACF_ASSERT_NEXT(a_accept_looks_up, in_valid_i && in_ready_o, state_q == ST_LOOK,
                    "accepted beat did not move to tag lookup")
  `SACF_ASSERT_NEXT(a_hit_counts, (state_q == ST_LOOK) && !oor_q && lk_hit,
                    hits_q == $past(hits_q) + CNT_W'(1), "hit count did not advance on a hit")
  `SACF_ASSERT_SAME(a_clear_quiet, state_q == ST_CLEAR, !in_ready_o && !out_valid_o,
                    "handshake active during the clearing pass")

endmodule

@@ verif/cache_access_checker.sv @@
// ----------------------------------------------------------------------------
// cache_access_checker
// Watches the configuration, request and reply ports of the set-associative
// cache, keeps its own copy of tags, line data, backing memory, fill pointers
// and hit count, and compares every reply beat with the predicted one.
// ----------------------------------------------------------------------------
module cache_access_checker
  import sacfwt_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [LIMIT_W-1:0]        cfg_wdata_i,
  input  logic                      in_valid_i,
  input  logic                      in_ready_i,
  input  logic                      mode_i,
  input  logic [ADDR_W-1:0]         address_i,
  input  logic signed [DATA_W-1:0]  write_value_i,
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  input  logic                      hit_i,
  input  logic signed [DATA_W-1:0]  read_value_i,
  input  logic [WAY_W-1:0]          way_used_i,
  input  logic                      status_i,
  input  logic [CNT_W-1:0]          total_hits_i,
  output int                        mismatches_o,
  output int                        pending_o,
  output int                        checked_o,
  output int                        hits_o,
  output int                        rejects_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_REJECTED = 1'b1;
  localparam int   MAX_PRINTED     = 40;

  typedef struct packed {
    logic             hit;
    word_t            read_value;
    way_t             way_used;
    logic             status;
    logic [CNT_W-1:0] total_hits;
  } cache_reply_t;

  blk_t             line_tag    [SETS*WAYS];
  word_t            line_words  [CD_WORDS];
  word_t            store_words [MEM_WORDS];
  way_t             victim_ptr  [SETS];
  logic [CNT_W-1:0] hit_total;
  logic [LIMIT_W-1:0] addr_limit;
  cache_reply_t     pending_replies [$];

  task automatic clear_model();
    for (int s = 0; s < SETS; s++) begin
      for (int w = 0; w < WAYS; w++) begin
        line_tag[s*WAYS+w] = blk_t'(w*SETS + s);
      end
      victim_ptr[s] = '0;
    end
    foreach (line_words[i]) line_words[i] = '0;
    foreach (store_words[i]) store_words[i] = '0;
    hit_total  = '0;
    addr_limit = LIMIT_RESET;
    pending_replies.delete();
  endtask

  // Looks an address below the limit up, refills on a miss, applies a write to
  // both line and backing memory, and returns the reply the cache should give.
  function automatic cache_reply_t lookup_and_update(logic is_write,
                                                     logic [ADDR_W-1:0] addr,
                                                     word_t wval);
    cache_reply_t r;
    int blk;
    int off;
    int set_idx;
    int way;
    int line;
    bit found;
    r = '0;
    r.total_hits = hit_total;
    if (addr >= addr_limit) begin
      r.status = STATUS_REJECTED;
      return r;
    end
    blk     = int'(addr) / WORDS_PER_BLOCK;
    off     = int'(addr) % WORDS_PER_BLOCK;
    set_idx = blk % SETS;
    found   = 1'b0;
    way     = 0;
    for (int w = 0; w < WAYS; w++) begin
      if (!found && line_tag[set_idx*WAYS+w] == blk_t'(blk)) begin
        found = 1'b1;
        way   = w;
      end
    end
    if (found) begin
      hit_total++;
    end else begin
      way = int'(victim_ptr[set_idx]);
      victim_ptr[set_idx] = way_t'((way + 1) % WAYS);
      line = set_idx*WAYS + way;
      line_tag[line] = blk_t'(blk);
      for (int k = 0; k < WORDS_PER_BLOCK; k++) begin
        line_words[line*WORDS_PER_BLOCK+k] = store_words[blk*WORDS_PER_BLOCK+k];
      end
    end
    line = set_idx*WAYS + way;
    if (is_write) begin
      store_words[addr] = wval;
      line_words[line*WORDS_PER_BLOCK+off] = wval;
    end
    r.hit        = found;
    r.read_value = line_words[line*WORDS_PER_BLOCK+off];
    r.way_used   = way_t'(way);
    r.status     = STATUS_OK;
    r.total_hits = hit_total;
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    mismatches_o++;
    // Keep the log readable when a fault repeats on every beat.
    if (mismatches_o <= MAX_PRINTED) begin
      $display("%0t ns: reply beat %0d, %s: got %h, expected %h",
               $realtime, checked_o, field, got, want);
    end
  endtask

  task automatic compare_reply();
    cache_reply_t want;
    if (pending_replies.size() == 0) begin
      report_mismatch("reply beat with no access outstanding", read_value_i, '0);
      return;
    end
    want = pending_replies.pop_front();
    if (status_i !== want.status) report_mismatch("status", status_i, want.status);
    if (hit_i !== want.hit) report_mismatch("hit", hit_i, want.hit);
    if (read_value_i !== want.read_value) begin
      report_mismatch("read_value", read_value_i, want.read_value);
    end
    if (way_used_i !== want.way_used) report_mismatch("way_used", way_used_i, want.way_used);
    if (total_hits_i !== want.total_hits) begin
      report_mismatch("total_hits", total_hits_i, want.total_hits);
    end
    if (want.status == STATUS_REJECTED) begin
      rejects_o++;
    end else if (want.hit) begin
      hits_o++;
    end
    checked_o++;
  endtask

  initial begin
    clear_model();
    mismatches_o = 0;
    pending_o    = 0;
    checked_o    = 0;
    hits_o       = 0;
    rejects_o    = 0;
  end

  // The reply is compared before a request taken on the same edge is
  // predicted, so an item can never be matched against its own prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_model();
    end else begin
      if (cfg_we_i) addr_limit = cfg_wdata_i;
      if (out_valid_i && out_ready_i) compare_reply();
      if (in_valid_i && in_ready_i) begin
        pending_replies = {pending_replies,
                           lookup_and_update(mode_i, address_i, write_value_i)};
      end
    end
    pending_o = pending_replies.size();
  end

endmodule

@@ verif/set_assoc_cache_fifo_write_through_tb.sv @@
// ----------------------------------------------------------------------------
// set_assoc_cache_fifo_write_through_tb
// Drives reads and writes into the four-way cache under randomly stalled
// handshakes and several address limits; a separate checker predicts each
// reply beat and counts mismatches, and this module gives the verdict.
// ----------------------------------------------------------------------------
module set_assoc_cache_fifo_write_through_tb;
  import sacfwt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int   CYCLE_LIMIT  = 200_000;
  localparam int   SETTLE_DELAY = 16;
  localparam int   HOT_WORDS    = 64;
  localparam logic ACCESS_READ  = 1'b0;
  localparam logic ACCESS_WRITE = 1'b1;

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_we;
  logic [LIMIT_W-1:0]       cfg_wdata;
  logic                     in_valid;
  logic                     in_ready;
  logic                     mode;
  logic [ADDR_W-1:0]        address;
  logic signed [DATA_W-1:0] write_value;
  logic                     out_valid;
  logic                     out_ready;
  logic                     hit;
  logic signed [DATA_W-1:0] read_value;
  logic [WAY_W-1:0]         way_used;
  logic                     status;
  logic [CNT_W-1:0]         total_hits;

  int mismatches;
  int outstanding;
  int checked;
  int hits_seen;
  int rejects_seen;
  int cycle_count;

  bit                 idle_on;
  logic [LIMIT_W-1:0] limit_now;

  set_assoc_cache_fifo_write_through DUT (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .mode_i        (mode),
    .address_i     (address),
    .write_value_i (write_value),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .hit_o         (hit),
    .read_value_o  (read_value),
    .way_used_o    (way_used),
    .status_o      (status),
    .total_hits_o  (total_hits)
  );

  cache_access_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .mode_i        (mode),
    .address_i     (address),
    .write_value_i (write_value),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .hit_i         (hit),
    .read_value_i  (read_value),
    .way_used_i    (way_used),
    .status_i      (status),
    .total_hits_i  (total_hits),
    .mismatches_o  (mismatches),
    .pending_o     (outstanding),
    .checked_o     (checked),
    .hits_o        (hits_seen),
    .rejects_o     (rejects_seen)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("set_assoc_cache_fifo_write_through_tb: errors");
    $finish;
  end

  // Reply side: ready drops in bursts of random length while idling is on.
  initial begin
    int stall_left;
    stall_left = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_ready  <= 1'b0;
        stall_left = $urandom_range(0, 7);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Called at a falling edge and returns at one, so that valid is written
  // once per step and stays high between back-to-back beats.
  task automatic send_access(logic wr, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] value);
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    mode        <= wr;
    address     <= addr;
    write_value <= value;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_DELAY) @(negedge clk);
  endtask

  task automatic program_limit(logic [LIMIT_W-1:0] value);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    limit_now = value;
  endtask

  // Most addresses fall in a hot window of a few blocks per set so that hits
  // and FIFO evictions both occur; the rest roam the limit or the whole map.
  task automatic send_random(int count);
    logic              wr;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] value;
    int span;
    int hot_base;
    int hot_span;
    int pick;
    span     = (int'(limit_now) > MEM_WORDS) ? MEM_WORDS : int'(limit_now);
    hot_span = (span < HOT_WORDS) ? span : HOT_WORDS;
    hot_base = (span > HOT_WORDS) ? $urandom_range(0, span - HOT_WORDS) : 0;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        addr = ADDR_W'(hot_base + int'($urandom_range(0, hot_span - 1)));
      end else if (pick < 8) begin
        addr = ADDR_W'($urandom_range(0, span - 1));
      end else begin
        addr = ADDR_W'($urandom_range(0, MEM_WORDS - 1));
      end
      wr = $urandom_range(0, 1) ? ACCESS_WRITE : ACCESS_READ;
      case ($urandom_range(0, 7))
        0:       value = 32'h8000_0000;
        1:       value = 32'h7fff_ffff;
        2:       value = '1;
        3:       value = '0;
        default: value = $urandom();
      endcase
      send_access(wr, addr, value);
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_wdata   = '0;
    in_valid    = 1'b0;
    mode        = ACCESS_READ;
    address     = '0;
    write_value = '0;
    idle_on     = 1'b1;
    limit_now   = LIMIT_RESET;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Block 0 starts out in way 0 of set 0, so the first access hits.
    send_access(ACCESS_READ, ADDR_W'(0), '0);
    send_access(ACCESS_WRITE, ADDR_W'(0), 32'h7fff_ffff);
    send_access(ACCESS_READ, ADDR_W'(1023), '0);
    send_access(ACCESS_WRITE, ADDR_W'(1023), 32'h8000_0000);
    send_access(ACCESS_WRITE, ADDR_W'(5), '1);
    send_access(ACCESS_READ, ADDR_W'(5), '0);
    // Five new blocks in set 0 walk the fill pointer once round and evict way 0
    // twice; block 0 must then come back from memory with the written word.
    for (int b = 16; b <= 32; b += 4) begin
      send_access(ACCESS_READ, ADDR_W'(b*WORDS_PER_BLOCK), '0);
    end
    send_access(ACCESS_READ, ADDR_W'(0), '0);
    send_access(ACCESS_WRITE, ADDR_W'(2), '0);

    program_limit(LIMIT_W'(1));
    send_access(ACCESS_READ, ADDR_W'(0), '0);
    send_access(ACCESS_READ, ADDR_W'(1), '0);
    send_access(ACCESS_WRITE, ADDR_W'(1023), 32'h1234_5678);
    program_limit(LIMIT_W'(0));
    send_access(ACCESS_READ, ADDR_W'(0), '0);
    send_access(ACCESS_WRITE, ADDR_W'(0), 32'hdead_beef);
    program_limit(LIMIT_W'(512));
    send_access(ACCESS_READ, ADDR_W'(511), '0);
    send_access(ACCESS_WRITE, ADDR_W'(512), 32'h5555_aaaa);
    program_limit(LIMIT_RESET);
    send_access(ACCESS_READ, ADDR_W'(1023), '0);

    send_random(190);
    idle_on = 1'b0;
    send_random(60);
    idle_on = 1'b1;
    program_limit(LIMIT_W'(700));
    send_random(120);
    program_limit(LIMIT_W'(1));
    send_random(30);
    program_limit(LIMIT_W'(333));
    send_random(120);
    program_limit(LIMIT_RESET);
    send_random(150);
    idle_on = 1'b0;
    send_random(60);
    settle();

    $display("%0d replies checked: %0d hits, %0d misses, %0d rejected addresses",
             checked, hits_seen, checked - hits_seen - rejects_seen, rejects_seen);
    $display("address limits 0, 1, 333, 512, 700 and 1024 visited, with and without stalls");
    if (mismatches == 0) begin
      $display("set_assoc_cache_fifo_write_through_tb: clean");
    end else begin
      $display("set_assoc_cache_fifo_write_through_tb: errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/sacfwt_pkg.sv
hdl/set_assoc_cache_fifo_write_through.sv
verif/cache_access_checker.sv
verif/set_assoc_cache_fifo_write_through_tb.sv
